// ----- src/sdpq_pkg.sv -----
// sdpq_pkg: shared types and constants of the sorted double-ended priority queue
// used by sdpq_cell and sorted_double_ended_priority_queue; no dependencies
package sdpq_pkg;

    localparam int PRI_W      = 32;
    localparam int ACT_W      = 2;
    localparam int STAT_W     = 3;
    localparam int PORT_PAY_W = 16;
    localparam int OCC_W      = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT  = 2'd0,
        ACT_POP_MIN = 2'd1,
        ACT_POP_MAX = 2'd2
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_POP_MIN,
        CELL_POP_MAX
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [PRI_W-1:0]  pri;
    } cell_cmd_t;

    typedef struct packed {
        logic vld;
        logic gt;
        logic last;
        logic g;
    } cell_stat_t;

endpackage

// ----- src/sdpq_cell.sv -----
// sdpq_cell: one slot of the sorted chain, holds a priority, a payload and a valid bit
// depends on sdpq_pkg; shifts toward either neighbor on insert and remove-minimum
module sdpq_cell #(
    parameter int PAY_W = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sdpq_pkg::cell_cmd_t                 cmd,
    input  logic                                any_gt,
    input  logic [PAY_W-1:0]                    new_pay,
    input  logic                                left_vld,
    input  logic                                left_g,
    input  logic signed [sdpq_pkg::PRI_W-1:0]   left_pri,
    input  logic [PAY_W-1:0]                    left_pay,
    input  logic                                right_vld,
    input  logic signed [sdpq_pkg::PRI_W-1:0]   right_pri,
    input  logic [PAY_W-1:0]                    right_pay,
    output sdpq_pkg::cell_stat_t                stat,
    output logic signed [sdpq_pkg::PRI_W-1:0]   pri,
    output logic [PAY_W-1:0]                    pay
);

    logic                                vld_reg, vld_next;
    logic signed [sdpq_pkg::PRI_W-1:0]   pri_reg, pri_next;
    logic [PAY_W-1:0]                    pay_reg, pay_next;
    logic                                g;

    // at or beyond the insertion point
    assign g = !vld_reg || (any_gt && (pri_reg >= cmd.pri));

    assign stat.vld  = vld_reg;
    assign stat.gt   = vld_reg && (pri_reg > cmd.pri);
    assign stat.last = vld_reg && !right_vld;
    assign stat.g    = g;
    assign pri       = pri_reg;
    assign pay       = pay_reg;

    always_comb begin
        vld_next = vld_reg;
        pri_next = pri_reg;
        pay_next = pay_reg;
        unique case (cmd.op)
            sdpq_pkg::CELL_INS: begin
                if (left_g) begin
                    pri_next = left_pri;
                    pay_next = left_pay;
                    vld_next = vld_reg || left_vld;
                end else if (g) begin
                    pri_next = cmd.pri;
                    pay_next = new_pay;
                    vld_next = 1'b1;
                end
            end
            sdpq_pkg::CELL_POP_MIN: begin
                pri_next = right_pri;
                pay_next = right_pay;
                vld_next = right_vld;
            end
            sdpq_pkg::CELL_POP_MAX: begin
                vld_next = vld_reg && right_vld;
            end
            sdpq_pkg::CELL_HOLD: begin
                vld_next = vld_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        pri_reg <= pri_next;
        pay_reg <= pay_next;
    end

endmodule

// ----- src/sorted_double_ended_priority_queue.sv -----
// sorted_double_ended_priority_queue: top level, a chain of sdpq_cell slots kept in
// ascending priority order plus a registered result stage; depends on sdpq_pkg, sdpq_cell
//
// channel   dir  tdata (low bit up)                                  tuser
// s_        in   priority_req[31:0], payload[47:32]                  action[1:0]
// m_        out  removed_payload[15:0], removed_priority[47:16],
//                occupancy[52:48], zero fill                         status[2:0]
//
// one transaction per cycle while m_tready keeps up; the result is registered the next cycle
// every cell compares its priority with the request in parallel, so the rate is set by
// that single compare plus the reduction across CAPACITY cells
// reset clears the cell valid bits, the entry count and the output valid flag at once
// a stalled result holds s_tready low until m_tready takes it
module sorted_double_ended_priority_queue #(
    parameter int CAPACITY     = 16,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // priority_req, payload
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // removed_payload, removed_priority, occupancy
    output logic [2:0]  m_tuser    // status
);

    localparam int SB = (PAYLOAD_BITS < sdpq_pkg::PORT_PAY_W) ?
                        PAYLOAD_BITS : sdpq_pkg::PORT_PAY_W;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                                accept;
    logic signed [sdpq_pkg::PRI_W-1:0]   req_pri;
    logic [SB-1:0]                       req_pay;
    sdpq_pkg::cell_cmd_t                 cmd;
    logic                                any_gt;

    sdpq_pkg::cell_stat_t                cell_stat [CAPACITY];
    logic signed [sdpq_pkg::PRI_W-1:0]   cell_pri  [CAPACITY];
    logic [SB-1:0]                       cell_pay  [CAPACITY];
    logic [CAPACITY-1:0]                 vld_vec;
    logic [CAPACITY-1:0]                 last_vec;

    logic [CW-1:0]                       count_reg, count_next;
    logic                                m_tvalid_reg;
    logic [55:0]                         m_tdata_reg, m_tdata_next;
    logic [2:0]                          m_tuser_reg;
    sdpq_pkg::status_t                   status;

    logic signed [sdpq_pkg::PRI_W-1:0]   max_pri, rm_pri;
    logic [SB-1:0]                       max_pay, rm_pay;
    logic [31:0]                         count_wide;
    logic [sdpq_pkg::OCC_W-1:0]          occ;
    logic [sdpq_pkg::PORT_PAY_W-1:0]     rm_pay16;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign req_pri  = $signed(s_tdata[31:0]);
    assign req_pay  = SB'(s_tdata[47:32]);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                                lv, lg, rv;
        logic signed [sdpq_pkg::PRI_W-1:0]   lpri, rpri;
        logic [SB-1:0]                       lpay, rpay;

        if (i == 0) begin : g_first
            assign lv   = 1'b0;
            assign lg   = 1'b0;
            assign lpri = '0;
            assign lpay = '0;
        end else begin : g_mid
            assign lv   = cell_stat[i-1].vld;
            assign lg   = cell_stat[i-1].g;
            assign lpri = cell_pri[i-1];
            assign lpay = cell_pay[i-1];
        end

        if (i == CAPACITY - 1) begin : g_end
            assign rv   = 1'b0;
            assign rpri = '0;
            assign rpay = '0;
        end else begin : g_inner
            assign rv   = cell_stat[i+1].vld;
            assign rpri = cell_pri[i+1];
            assign rpay = cell_pay[i+1];
        end

        sdpq_cell #(.PAY_W(SB)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .any_gt    (any_gt),
            .new_pay   (req_pay),
            .left_vld  (lv),
            .left_g    (lg),
            .left_pri  (lpri),
            .left_pay  (lpay),
            .right_vld (rv),
            .right_pri (rpri),
            .right_pay (rpay),
            .stat      (cell_stat[i]),
            .pri       (cell_pri[i]),
            .pay       (cell_pay[i])
        );

        assign vld_vec[i]  = cell_stat[i].vld;
        assign last_vec[i] = cell_stat[i].last;
    end

    // largest entry and any entry above the request
    always_comb begin
        any_gt  = 1'b0;
        max_pri = '0;
        max_pay = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            any_gt = any_gt | cell_stat[i].gt;
            if (cell_stat[i].last) begin
                max_pri = max_pri | cell_pri[i];
                max_pay = max_pay | cell_pay[i];
            end
        end
    end

    always_comb begin
        cmd.op     = sdpq_pkg::CELL_HOLD;
        cmd.pri    = req_pri;
        status     = sdpq_pkg::ST_NULL;
        count_next = count_reg;
        rm_pri     = '0;
        rm_pay     = '0;
        unique case (s_tuser)
            sdpq_pkg::ACT_INSERT: begin
                if (req_pay == '0) begin
                    status = sdpq_pkg::ST_NULL;
                end else if (count_reg == CW'(CAPACITY)) begin
                    status = sdpq_pkg::ST_FULL;
                end else begin
                    status     = sdpq_pkg::ST_INSERTED;
                    cmd.op     = accept ? sdpq_pkg::CELL_INS : sdpq_pkg::CELL_HOLD;
                    count_next = count_reg + 1'b1;
                end
            end
            sdpq_pkg::ACT_POP_MIN: begin
                if (count_reg == '0) begin
                    status = sdpq_pkg::ST_EMPTY;
                end else begin
                    status     = sdpq_pkg::ST_REMOVED;
                    cmd.op     = accept ? sdpq_pkg::CELL_POP_MIN : sdpq_pkg::CELL_HOLD;
                    count_next = count_reg - 1'b1;
                    rm_pri     = cell_pri[0];
                    rm_pay     = cell_pay[0];
                end
            end
            sdpq_pkg::ACT_POP_MAX: begin
                if (count_reg == '0) begin
                    status = sdpq_pkg::ST_EMPTY;
                end else begin
                    status     = sdpq_pkg::ST_REMOVED;
                    cmd.op     = accept ? sdpq_pkg::CELL_POP_MAX : sdpq_pkg::CELL_HOLD;
                    count_next = count_reg - 1'b1;
                    rm_pri     = max_pri;
                    rm_pay     = max_pay;
                end
            end
            default: begin
                status = sdpq_pkg::ST_NULL;
            end
        endcase
    end

    assign count_wide   = 32'(count_next);
    assign occ          = count_wide[sdpq_pkg::OCC_W-1:0];
    assign rm_pay16     = sdpq_pkg::PORT_PAY_W'(rm_pay);
    assign m_tdata_next = {3'b000, occ, rm_pri, rm_pay16};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (s_tready) begin
                m_tvalid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= status;
        end
    end

    // valid bits form a run from cell 0; the check is that their number equals the entry count
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(vld_vec) == 32'(count_reg))
        else $error("cell valid bits disagree with entry count");

    a_one_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(last_vec) && ((count_reg == '0) == !vld_vec[0]))
        else $error("more than one tail cell or empty flag mismatch");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && status == sdpq_pkg::ST_INSERTED) |=>
        (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted insert did not grow the queue");

endmodule
